// File: hw/rtl/and_on_delay_order_detect_assert.svh
// Assertion macros for the two-input AND with on-delay and order detection.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef AND_ON_DELAY_ORDER_DETECT_ASSERT_SVH
`define AND_ON_DELAY_ORDER_DETECT_ASSERT_SVH

// same-cycle implication
`define AOD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AOD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/aodod_pkg.sv
// Shared types and constants for the AND on-delay order detector.
// No dependencies.
package aodod_pkg;

    localparam int CFG_DATA_W = 20;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [1:0] VAL_FALSE = 2'd0;
    localparam logic [1:0] VAL_TRUE  = 2'd1;
    localparam logic [1:0] VAL_UNDEF = 2'd2;
    localparam logic [1:0] VAL_RSVD  = 2'd3;

    localparam logic CFG_OUTPUT_DELAY = 1'b0;
    localparam logic CFG_ORDER_WINDOW = 1'b1;

    localparam logic PORT_ORD1 = 1'b0;
    localparam logic PORT_ORD2 = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [1:0] in1_value;
        logic [1:0] in2_value;
    } t_item;

    typedef struct packed {
        logic level_valid;
        logic level;
        logic pulse_valid;
        logic pulse_port;
    } t_result;

    function automatic logic [1:0] norm_value(input logic [1:0] v);
        return (v == VAL_RSVD) ? VAL_UNDEF : v;
    endfunction

endpackage

// File: hw/rtl/aodod_if.sv
// Request and result channel interfaces, valid/ready handshake.
// Depends on nothing.
interface aodod_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] in1_value;
    logic [1:0] in2_value;

    modport source (output valid, kind, in1_value, in2_value, input ready);
    modport sink   (input valid, kind, in1_value, in2_value, output ready);
endinterface

interface aodod_out_if;
    logic valid;
    logic ready;
    logic level_valid;
    logic level;
    logic pulse_valid;
    logic pulse_port;

    modport source (output valid, level_valid, level, pulse_valid, pulse_port, input ready);
    modport sink   (input valid, level_valid, level, pulse_valid, pulse_port, output ready);
endinterface

// File: hw/rtl/and_on_delay_order_detect.sv
// Top level of the two-input AND gate with on-delay and rise-order detection.
// Depends on aodod_pkg, aodod_if, aodod_core and the assertion macro header.
//
// Usage:
//   i_req carries one request per handshake: a millisecond tick (kind = 1)
//   or a new pair of three-valued input levels (kind = 0).
//   o_rsp returns exactly one result per request, in order: a level change
//   flag and value, and an ord1/ord2 pulse flag and port.
//   The configuration port writes output_delay_ms (index 0) or order_window_ms (index 1);
//   the user writes only while no request is in flight; the block does not enforce it.
// Output: a registered result appears on o_rsp in the cycle after its request is taken.
// Throughput: one request per cycle unless a result is held by a low o_rsp.ready;
//   the state update is a single pass of compares, a 40-bit increment and subtract, set by the time counter path.
// Reset: synchronous, active low; clears counters, rise times, timer, the
//   output level, the configuration and the result valid flag; both inputs
//   read as undefined.
// Stall: the result register holds while o_rsp.ready is low; i_req.ready
//   stays high whenever the register is empty or being drained.
`include "and_on_delay_order_detect_assert.svh"

module and_on_delay_order_detect
    import aodod_pkg::*;
#(
    parameter int TIME_WIDTH = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    aodod_in_if.sink              i_req,
    aodod_out_if.source           o_rsp
);

    logic    r_out_valid, n_out_valid;
    t_result r_out, w_res;
    t_item   w_item;
    logic    w_acc, w_drain;

    assign w_drain     = o_rsp.ready;
    assign i_req.ready = !r_out_valid || w_drain;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_item      = '{kind: i_req.kind, in1_value: i_req.in1_value,
                           in2_value: i_req.in2_value};

    aodod_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (w_acc),
        .i_item     (w_item),
        .o_res      (w_res)
    );

    assign n_out_valid = w_acc || (r_out_valid && !w_drain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.level_valid = r_out.level_valid;
    assign o_rsp.level       = r_out.level;
    assign o_rsp.pulse_valid = r_out.pulse_valid;
    assign o_rsp.pulse_port  = r_out.pulse_port;

    `AOD_ASSERT_NEXT(a_result_follows, w_acc, r_out_valid)
    `AOD_ASSERT_NEXT(a_tick_no_pulse, w_acc && (i_req.kind == KIND_TICK), !r_out.pulse_valid)
    `AOD_ASSERT_NEXT(a_event_no_rise, w_acc && (i_req.kind == KIND_EVENT),
                     !(r_out.level_valid && r_out.level))
    `AOD_ASSERT_NOW(a_full_stall, r_out_valid && !w_drain, !i_req.ready)

endmodule

// File: hw/rtl/aodod_core.sv
// State and single-pass update of the AND gate, on-delay and order detector.
// Depends on aodod_pkg.
module aodod_core
    import aodod_pkg::*;
#(
    parameter int TIME_WIDTH = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_acc,
    input  t_item                 i_item,
    output t_result               o_res
);

    logic [CFG_DATA_W-1:0] r_delay_cfg, r_window_cfg;
    logic [TIME_WIDTH-1:0] r_now, n_now;
    logic [TIME_WIDTH-1:0] r_rise1, n_rise1, r_rise2, n_rise2;
    logic [1:0]            r_last1, n_last1, r_last2, n_last2;
    logic                  r_level, n_level, r_armed, n_armed;
    logic [CFG_DATA_W-1:0] r_left, n_left;

    logic [1:0]            v1, v2;
    logic                  t1, t2, fall1, fall2, ordering, both_set;
    logic [TIME_WIDTH-1:0] age1, age2, window_ext;

    assign v1         = norm_value(i_item.in1_value);
    assign v2         = norm_value(i_item.in2_value);
    assign t1         = (v1 == VAL_TRUE);
    assign t2         = (v2 == VAL_TRUE);
    assign ordering   = (r_window_cfg != '0);
    assign fall1      = ordering && (v1 == VAL_FALSE) && (r_last1 == VAL_TRUE);
    assign fall2      = ordering && (v2 == VAL_FALSE) && (r_last2 == VAL_TRUE);
    assign age1       = r_now - r_rise1;
    assign age2       = r_now - r_rise2;
    assign window_ext = TIME_WIDTH'(r_window_cfg);
    assign both_set   = (r_rise1 != '0) && (r_rise2 != '0);

    always_comb begin
        n_now   = r_now;
        n_rise1 = r_rise1;
        n_rise2 = r_rise2;
        n_last1 = r_last1;
        n_last2 = r_last2;
        n_level = r_level;
        n_armed = r_armed;
        n_left  = r_left;
        o_res   = '0;
        if (i_item.kind == KIND_TICK) begin
            n_now = r_now + TIME_WIDTH'(1);
            if (r_armed) begin
                if (r_left <= CFG_DATA_W'(1)) begin
                    n_armed           = 1'b0;
                    n_left            = '0;
                    n_level           = 1'b1;
                    o_res.level_valid = 1'b1;
                    o_res.level       = 1'b1;
                end else begin
                    n_left = r_left - CFG_DATA_W'(1);
                end
            end
        end else begin
            if (ordering && t1 && (r_last1 == VAL_FALSE)) begin
                n_rise1 = r_now;
            end
            if (ordering && t2 && (r_last2 == VAL_FALSE)) begin
                n_rise2 = r_now;
            end
            n_last1 = v1;
            n_last2 = v2;
            if (ordering && !t1 && !t2 && both_set) begin
                priority if (fall1 && (r_rise2 < r_rise1) && (age2 <= window_ext)) begin
                    o_res.pulse_valid = 1'b1;
                    o_res.pulse_port  = PORT_ORD2;
                end else if (fall2 && (r_rise1 < r_rise2) && (age1 <= window_ext)) begin
                    o_res.pulse_valid = 1'b1;
                    o_res.pulse_port  = PORT_ORD1;
                end else begin
                    o_res.pulse_valid = 1'b0;
                end
            end
            if (!t1 || !t2) begin
                if (r_level) begin
                    n_level           = 1'b0;
                    o_res.level_valid = 1'b1;
                    o_res.level       = 1'b0;
                end else begin
                    n_armed = 1'b0;
                    n_left  = '0;
                end
            end else if (!r_level && !r_armed) begin
                n_armed = 1'b1;
                n_left  = r_delay_cfg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_cfg  <= '0;
            r_window_cfg <= '0;
            r_now        <= '0;
            r_rise1      <= '0;
            r_rise2      <= '0;
            r_last1      <= VAL_UNDEF;
            r_last2      <= VAL_UNDEF;
            r_level      <= 1'b0;
            r_armed      <= 1'b0;
            r_left       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_OUTPUT_DELAY: r_delay_cfg  <= i_cfg_data;
                    CFG_ORDER_WINDOW: r_window_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_acc) begin
                r_now   <= n_now;
                r_rise1 <= n_rise1;
                r_rise2 <= n_rise2;
                r_last1 <= n_last1;
                r_last2 <= n_last2;
                r_level <= n_level;
                r_armed <= n_armed;
                r_left  <= n_left;
            end
        end
    end

endmodule
